### src/cstf_pkg.sv
// Shared types, text constants and the control store for the character stuffing framer.
// No dependencies; imported by cstf_useq, cstf_dpath and character_stuffing_framer.
package cstf_pkg;

    localparam int WIN_DEPTH = 6;

    typedef logic [5:0] t_uaddr;
    typedef logic [2:0] t_wcnt;
    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        ES_NONE,
        ES_CONST,
        ES_HEAD
    } t_esel;

    typedef enum logic [1:0] {
        LM_NEVER,
        LM_ALWAYS,
        LM_HDR_END,
        LM_DEC_END
    } t_lmode;

    typedef enum logic [2:0] {
        SQ_NEXT,
        SQ_JUMP,
        SQ_WAIT_IN,
        SQ_DISPATCH,
        SQ_DECIDE
    } t_seq;

    typedef struct packed {
        t_esel  esel;
        t_byte  chr;
        t_lmode lmode;
        logic   done;
        t_seq   seq;
        t_uaddr target;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   go;
    } t_ctrl;

    typedef struct packed {
        logic started;
        logic fin;
        logic win_empty;
        logic win_full;
        logic mark_hit;
        logic esc_hit;
        logic slot_free;
    } t_stat;

    localparam t_uaddr U_IDLE     = 6'd0;
    localparam t_uaddr U_HDR      = 6'd1;
    localparam t_uaddr U_HDR_END  = 6'd12;
    localparam t_uaddr U_DISP     = 6'd13;
    localparam t_uaddr U_DEC      = 6'd14;
    localparam t_uaddr U_MPRE     = 6'd15;
    localparam t_uaddr U_MPRE_END = 6'd17;
    localparam t_uaddr U_POP      = 6'd18;
    localparam t_uaddr U_POP_ESC  = 6'd21;
    localparam t_uaddr U_POP_LAST = 6'd23;
    localparam t_uaddr U_EPRE     = 6'd24;
    localparam t_uaddr U_EPRE_END = 6'd26;
    localparam t_uaddr U_TRL      = 6'd27;
    localparam t_uaddr U_TRL_END  = 6'd38;

    localparam t_byte HDR_TXT [12] = '{
        8'h44, 8'h4C, 8'h45, 8'h53, 8'h4F, 8'h48,
        8'h44, 8'h4C, 8'h45, 8'h53, 8'h4F, 8'h54
    };
    localparam t_byte TRL_TXT [12] = '{
        8'h44, 8'h4C, 8'h45, 8'h45, 8'h4F, 8'h54,
        8'h44, 8'h4C, 8'h45, 8'h45, 8'h4F, 8'h48
    };
    localparam t_byte MARK_TXT [4][6] = '{
        '{8'h44, 8'h4C, 8'h45, 8'h53, 8'h4F, 8'h48},
        '{8'h44, 8'h4C, 8'h45, 8'h53, 8'h4F, 8'h54},
        '{8'h44, 8'h4C, 8'h45, 8'h45, 8'h4F, 8'h54},
        '{8'h44, 8'h4C, 8'h45, 8'h45, 8'h4F, 8'h48}
    };
    localparam t_byte ESC_TXT [3] = '{8'h45, 8'h53, 8'h43};

    function automatic t_uword ucode_rom(input t_uaddr a);
        t_uword     w;
        logic [3:0] k;
        w = '{esel: ES_NONE, chr: 8'h00, lmode: LM_NEVER, done: 1'b0,
              seq: SQ_JUMP, target: U_IDLE};
        k = '0;
        if (a == U_IDLE) begin
            w.seq = SQ_WAIT_IN;
        end else if (a >= U_HDR && a <= U_HDR_END) begin
            k      = 4'(a - U_HDR);
            w.esel = ES_CONST;
            w.chr  = HDR_TXT[k];
            w.seq  = SQ_NEXT;
            if (a == U_HDR_END) begin
                w.lmode = LM_HDR_END;
            end
        end else if (a == U_DISP) begin
            w.seq = SQ_DISPATCH;
        end else if (a == U_DEC) begin
            w.seq = SQ_DECIDE;
        end else if (a >= U_MPRE && a <= U_MPRE_END) begin
            k      = 4'(a - U_MPRE);
            w.esel = ES_CONST;
            w.chr  = ESC_TXT[k[1:0]];
            w.seq  = SQ_NEXT;
        end else if (a >= U_POP && a <= U_POP_LAST) begin
            w.esel = ES_HEAD;
            w.seq  = SQ_NEXT;
            if (a == U_POP_LAST) begin
                w.lmode  = LM_DEC_END;
                w.seq    = SQ_JUMP;
                w.target = U_DISP;
            end
        end else if (a >= U_EPRE && a <= U_EPRE_END) begin
            k      = 4'(a - U_EPRE);
            w.esel = ES_CONST;
            w.chr  = ESC_TXT[k[1:0]];
            w.seq  = SQ_NEXT;
            if (a == U_EPRE_END) begin
                w.seq    = SQ_JUMP;
                w.target = U_POP_ESC;
            end
        end else if (a >= U_TRL && a <= U_TRL_END) begin
            k      = 4'(a - U_TRL);
            w.esel = ES_CONST;
            w.chr  = TRL_TXT[k];
            w.seq  = SQ_NEXT;
            if (a == U_TRL_END) begin
                w.lmode  = LM_ALWAYS;
                w.done   = 1'b1;
                w.seq    = SQ_JUMP;
                w.target = U_IDLE;
            end
        end
        return w;
    endfunction

endpackage

### src/cstf_useq.sv
// Microprogram sequencer: step counter, control store read and branch selection.
// Depends on cstf_pkg; branch conditions come from cstf_dpath.
module cstf_useq
    import cstf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_uaddr r_upc;
    t_uaddr n_upc;
    t_uword uw;
    logic   go;

    assign uw = ucode_rom(r_upc);
    assign go = (uw.esel == ES_NONE || i_stat.slot_free) &&
                (uw.seq != SQ_WAIT_IN || i_in_valid);

    always_comb begin
        case (uw.seq)
            SQ_NEXT:     n_upc = r_upc + 6'd1;
            SQ_JUMP:     n_upc = uw.target;
            SQ_WAIT_IN:  n_upc = i_stat.started ? U_DISP : U_HDR;
            SQ_DISPATCH: begin
                if (i_stat.fin) begin
                    n_upc = i_stat.win_empty ? U_TRL : U_DEC;
                end else begin
                    n_upc = i_stat.win_full ? U_DEC : U_IDLE;
                end
            end
            SQ_DECIDE: begin
                if (i_stat.mark_hit) begin
                    n_upc = U_MPRE;
                end else if (i_stat.esc_hit) begin
                    n_upc = U_EPRE;
                end else begin
                    n_upc = U_POP_LAST;
                end
            end
            default:     n_upc = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else if (go) begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = '{uw: uw, go: go};

endmodule

### src/cstf_dpath.sv
// Datapath: lookahead window, fill count, frame flags, marker match and output register.
// Depends on cstf_pkg; driven by the control word from cstf_useq.
module cstf_dpath
    import cstf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_byte i_data_byte,
    input  logic  i_end_of_frame,
    input  logic  i_out_stall,
    output t_stat o_stat,
    output logic  o_out_valid,
    output t_byte o_out_byte,
    output logic  o_last_of_run,
    output logic  o_frame_done
);

    t_byte r_win [WIN_DEPTH];
    t_wcnt r_count;
    logic  r_started;
    logic  r_fin;
    logic  r_ovalid;
    t_byte r_obyte;
    logic  r_olast;
    logic  r_odone;

    logic  take_in;
    logic  pop;
    logic  emit;
    logic  mark_eq;
    logic  esc_eq;
    logic  n_last;
    t_byte n_byte;

    assign take_in = i_ctrl.go && i_ctrl.uw.seq == SQ_WAIT_IN;
    assign pop     = i_ctrl.go && i_ctrl.uw.esel == ES_HEAD;
    assign emit    = i_ctrl.go && i_ctrl.uw.esel != ES_NONE;

    always_comb begin
        logic m;
        mark_eq = 1'b0;
        for (int j = 0; j < 4; j++) begin
            m = 1'b1;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                m = m && (r_win[i] == MARK_TXT[j][i]);
            end
            mark_eq = mark_eq || m;
        end
        esc_eq = (r_win[0] == ESC_TXT[0]) && (r_win[1] == ESC_TXT[1]) &&
                 (r_win[2] == ESC_TXT[2]);
    end

    always_comb begin
        case (i_ctrl.uw.lmode)
            LM_NEVER:   n_last = 1'b0;
            LM_ALWAYS:  n_last = 1'b1;
            LM_HDR_END: n_last = !r_fin && (r_count != t_wcnt'(WIN_DEPTH));
            LM_DEC_END: n_last = !r_fin;
            default:    n_last = 1'b0;
        endcase
        n_byte = (i_ctrl.uw.esel == ES_HEAD) ? r_win[0] : i_ctrl.uw.chr;
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_win[r_count] <= i_data_byte;
        end else if (pop) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_started <= 1'b0;
            r_fin     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (take_in) begin
                r_count   <= r_count + t_wcnt'(1);
                r_started <= 1'b1;
                r_fin     <= i_end_of_frame;
            end else if (pop) begin
                r_count <= r_count - t_wcnt'(1);
            end else if (i_ctrl.go && i_ctrl.uw.done) begin
                r_count   <= '0;
                r_started <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= n_byte;
            r_olast <= n_last;
            r_odone <= i_ctrl.uw.done;
        end
    end

    assign o_stat = '{
        started:   r_started,
        fin:       r_fin,
        win_empty: r_count == '0,
        win_full:  r_count == t_wcnt'(WIN_DEPTH),
        mark_hit:  (r_count == t_wcnt'(WIN_DEPTH)) && mark_eq,
        esc_hit:   (r_count >= t_wcnt'(3)) && esc_eq,
        slot_free: !r_ovalid || !i_out_stall
    };

    assign o_out_valid   = r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_last_of_run = r_olast;
    assign o_frame_done  = r_odone;

endmodule

### src/character_stuffing_framer.sv
// Top level of the character stuffing framer: sequencer plus datapath.
// Depends on cstf_pkg, cstf_useq and cstf_dpath.
//
// Input channel: i_in_valid / o_in_stall carry one payload byte per transaction,
// with i_end_of_frame high on the final byte of a frame. Output channel:
// o_out_valid / i_out_stall carry one stuffed byte per transaction, with
// o_last_of_run on the final byte caused by an input and o_frame_done on the
// final trailer byte. The first byte of a frame brings out the header; a frame
// end flushes the six-byte lookahead window and appends the trailer.
// Markers are sent behind ESC, ESC is doubled, other bytes pass unchanged.
// One control word per cycle comes from a microprogram counter, unless an
// output step waits for a free slot or the idle step for input. Each output byte
// is one step; an input passes an accept and a dispatch step, and a decision adds
// a decide step before dispatch again. The first byte of a frame also runs the
// header steps, a frame end the flush and trailer steps. Input is taken only
// while the sequencer waits at its idle step, so at most one input is in work.
// Output goes through one register: the next byte is formed while the current
// one waits. A stall on the output holds the sequencer at its next output step.
// Reset (synchronous, active low) empties the window, clears the frame flag and
// the output valid flag; the first input after reset opens a new frame.
module character_stuffing_framer
    import cstf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_frame,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_frame_done
);

    t_ctrl ctrl;
    t_stat stat;

    cstf_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    cstf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_data_byte    (i_data_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_out_stall    (i_out_stall),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_frame_done   (o_frame_done)
    );

    assign o_in_stall = (ctrl.uw.seq != SQ_WAIT_IN);

endmodule

### tb/cstf_checker.sv
// Checker for the character stuffing framer: watches both channels, predicts the stuffed stream.
// Depends on cstf_pkg for the byte type and the window depth; hands counts to the testbench top.
module cstf_checker
    import cstf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_stall,
    input  t_byte i_data_byte,
    input  logic  i_end_of_frame,
    input  logic  i_out_valid,
    input  logic  i_out_stall,
    input  t_byte i_out_byte,
    input  logic  i_last_of_run,
    input  logic  i_frame_done,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_result_count,
    output int    o_frame_count
);

    localparam logic [47:0] MARKERS [4] = '{"DLESOH", "DLESOT", "DLEEOT", "DLEEOH"};
    localparam logic [47:0] ESC_SEQ     = 48'("ESC");
    localparam logic [95:0] HEADER      = "DLESOHDLESOT";
    localparam logic [95:0] TRAILER     = "DLEEOTDLEEOH";

    typedef struct packed {
        t_byte chr;
        logic  last;
        logic  done;
    } t_stuffed;

    t_stuffed stuffed_q [$];
    t_byte    run_q [$];
    t_byte    window [WIN_DEPTH];
    int       window_fill;
    logic     in_frame;
    int       fails;
    int       results;
    int       frames;

    function automatic bit window_starts_with(input logic [47:0] pat, input int n);
        bit hit;
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (window[i] != pat[8*(n-1-i) +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    task automatic emit_text(input logic [95:0] txt, input int n);
        for (int i = 0; i < n; i++) begin
            run_q.push_back(txt[8*(n-1-i) +: 8]);
        end
    endtask

    task automatic drop_head(input int n);
        if (n >= window_fill) begin
            window_fill = 0;
        end else begin
            for (int i = 0; i + n < window_fill; i++) begin
                window[i] = window[i+n];
            end
            window_fill -= n;
        end
    endtask

    task automatic resolve_head();
        bit matched;
        matched = 1'b0;
        if (window_fill >= 6) begin
            for (int m = 0; m < 4 && !matched; m++) begin
                if (window_starts_with(MARKERS[m], 6)) begin
                    emit_text(96'(ESC_SEQ), 3);
                    emit_text(96'(MARKERS[m]), 6);
                    drop_head(6);
                    matched = 1'b1;
                end
            end
        end
        if (!matched && window_fill >= 3 && window_starts_with(ESC_SEQ, 3)) begin
            emit_text(96'(ESC_SEQ), 3);
            emit_text(96'(ESC_SEQ), 3);
            drop_head(3);
            matched = 1'b1;
        end
        if (!matched) begin
            run_q.push_back(window[0]);
            drop_head(1);
        end
    endtask

    task automatic predict_stuffing(input t_byte b, input logic eof);
        int done_at;
        done_at = -1;
        run_q.delete();
        if (!in_frame) begin
            emit_text(HEADER, 12);
            in_frame = 1'b1;
        end
        window[window_fill] = b;
        window_fill++;
        if (eof) begin
            while (window_fill > 0) begin
                resolve_head();
            end
            emit_text(TRAILER, 12);
            done_at     = run_q.size() - 1;
            window_fill = 0;
            in_frame    = 1'b0;
        end else if (window_fill >= WIN_DEPTH) begin
            resolve_head();
        end
        for (int k = 0; k < run_q.size(); k++) begin
            stuffed_q.push_back('{chr: run_q[k], last: (k == run_q.size() - 1),
                                  done: (k == done_at)});
        end
    endtask

    always @(posedge i_clk) begin
        t_stuffed want;
        if (!i_rst_n) begin
            window_fill = 0;
            in_frame    = 1'b0;
            stuffed_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_stuffing(i_data_byte, i_end_of_frame);
            end
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (i_frame_done) begin
                    frames++;
                end
                if (stuffed_q.size() == 0) begin
                    $error("unexpected output transaction: out_byte %02h", i_out_byte);
                    fails++;
                end else begin
                    want = stuffed_q.pop_front();
                    if (i_out_byte !== want.chr) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.chr, i_out_byte);
                        fails++;
                    end
                    if (i_last_of_run !== want.last) begin
                        $error("last_of_run mismatch: expected %0b, actual %0b",
                               want.last, i_last_of_run);
                        fails++;
                    end
                    if (i_frame_done !== want.done) begin
                        $error("frame_done mismatch: expected %0b, actual %0b",
                               want.done, i_frame_done);
                        fails++;
                    end
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= stuffed_q.size();
        o_result_count <= results;
        o_frame_count  <= frames;
    end

endmodule

### tb/tb.sv
// Testbench top for the character stuffing framer: clock, reset, stimulus and verdict.
// Depends on cstf_pkg, character_stuffing_framer and cstf_checker.
module tb;
    import cstf_pkg::*;

    logic  clk            = 1'b0;
    logic  rst_n          = 1'b0;
    logic  in_valid       = 1'b0;
    t_byte data_byte      = 8'h00;
    logic  end_of_frame   = 1'b0;
    logic  out_stall      = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_byte o_out_byte;
    logic  o_last_of_run;
    logic  o_frame_done;

    int    fail_count;
    int    pending;
    int    result_count;
    int    frame_count;
    int    sent_items     = 0;
    int    send_idle_pct  = 31;
    int    recv_idle_pct  = 80;

    string marker_txt     = "DLESOHDLESOTDLEEOTDLEEOH";
    string letters        = "DLESOHTC";

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    character_stuffing_framer u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (data_byte),
        .i_end_of_frame (end_of_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_frame_done   (o_frame_done)
    );

    cstf_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (data_byte),
        .i_end_of_frame (end_of_frame),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .i_out_byte     (o_out_byte),
        .i_last_of_run  (o_last_of_run),
        .i_frame_done   (o_frame_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_frame_count  (frame_count)
    );

    always @(posedge clk) begin
        out_stall <= rst_n ? ($urandom_range(99) < recv_idle_pct) : 1'b0;
    end

    task automatic push_byte(input t_byte b, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_frame <= eof;
        @(posedge clk);
        while (o_in_stall) begin
            @(posedge clk);
        end
        sent_items++;
    endtask

    task automatic send_text(input string s, input logic eof_at_end);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(t_byte'(s[i]), eof_at_end && (i == s.len() - 1));
        end
    endtask

    task automatic send_random_frame();
        t_byte frame [$];
        int    len;
        int    pick;
        int    base;
        int    n;
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        while (frame.size() < len) begin
            pick = $urandom_range(9);
            base = 6 * $urandom_range(3);
            case (pick)
                0, 1, 2: begin
                    for (int i = 0; i < 6; i++) frame.push_back(t_byte'(marker_txt[base+i]));
                end
                3, 4: begin
                    frame.push_back("E");
                    frame.push_back("S");
                    frame.push_back("C");
                end
                5: begin
                    n = $urandom_range(5, 1);
                    for (int i = 0; i < n; i++) frame.push_back(t_byte'(marker_txt[base+i]));
                end
                6: begin
                    frame.push_back("E");
                    if ($urandom_range(1)) frame.push_back("S");
                end
                7: begin
                    frame.push_back(t_byte'(letters[$urandom_range(letters.len() - 1)]));
                end
                default: begin
                    frame.push_back(t_byte'($urandom_range(255)));
                end
            endcase
        end
        while (frame.size() > len) begin
            void'(frame.pop_back());
        end
        for (int i = 0; i < len; i++) begin
            push_byte(frame[i], i == len - 1);
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        send_text("DLESOHZ", 1'b1);
        send_text("DLEEOT", 1'b1);
        send_text("ESC", 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7F, 1'b0);
        send_text("ES", 1'b1);

        while (sent_items < 190) send_random_frame();
        send_idle_pct = 80;
        recv_idle_pct = 31;
        while (sent_items < 360) send_random_frame();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent_items < 520) send_random_frame();
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);

        $display("Sent %0d payload bytes; checked %0d stuffed bytes over %0d completed frames,",
                 sent_items, result_count, frame_count);
        $display("under sender-heavy, receiver-heavy and back-to-back handshake pressure.");
        if (fail_count == 0) begin
            $display("character_stuffing_framer verification clean");
        end else begin
            $display("character_stuffing_framer verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("character_stuffing_framer verification failed");
        $finish;
    end

endmodule

### sim.f
src/cstf_pkg.sv
src/cstf_useq.sv
src/cstf_dpath.sv
src/character_stuffing_framer.sv
tb/cstf_checker.sv
tb/tb.sv
